>>> rtl/tia_pkg.sv
`default_nettype none

package tia_pkg;

  localparam int unsigned DATA_W    = 64;
  localparam int unsigned HALF_W    = DATA_W / 2;
  localparam int unsigned DIV_STEPS = DATA_W;

  // Command codes
  localparam logic [3:0] CMD_ADD   = 4'd0;
  localparam logic [3:0] CMD_SUB   = 4'd1;
  localparam logic [3:0] CMD_MUL   = 4'd2;
  localparam logic [3:0] CMD_DIV   = 4'd3;
  localparam logic [3:0] CMD_LT    = 4'd4;
  localparam logic [3:0] CMD_GT    = 4'd5;
  localparam logic [3:0] CMD_LE    = 4'd6;
  localparam logic [3:0] CMD_GE    = 4'd7;
  localparam logic [3:0] CMD_TRUTH = 4'd8;
  localparam logic [3:0] CMD_NOT   = 4'd9;

  // Operand tags
  localparam logic [2:0] TAG_NONE = 3'd0;
  localparam logic [2:0] TAG_BOOL = 3'd1;
  localparam logic [2:0] TAG_INT  = 3'd2;
  localparam logic [2:0] TAG_OBJ  = 3'd3;

  // Result tags
  localparam logic [1:0] RES_BOOL = 2'd0;
  localparam logic [1:0] RES_INT  = 2'd1;
  localparam logic [1:0] RES_ERR  = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_TYPE = 2'd1;
  localparam logic [1:0] ERR_DIV0 = 2'd2;
  localparam logic [1:0] ERR_CONV = 2'd3;

  // Captured input item
  typedef struct packed {
    logic [3:0]        cmd;
    logic [2:0]        ltag;
    logic [2:0]        rtag;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } in_t;

  // Work carried down the pipeline
  typedef struct packed {
    logic [1:0]        tag;
    logic [1:0]        err;
    logic              is_mul;
    logic              is_div;
    logic              neg;
    logic [DATA_W-1:0] val;
    logic [DATA_W-1:0] pll;
    logic [HALF_W-1:0] plh;
    logic [HALF_W-1:0] phl;
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] dq;
    logic [DATA_W-1:0] dvs;
  } work_t;

  // One restoring division step: shift in a dividend bit, trial subtract
  function automatic work_t div_step(input work_t w);
    logic [DATA_W:0] r;
    logic            ge;
    work_t           o;
    o  = w;
    r  = {w.rem, w.dq[DATA_W-1]};
    ge = (r >= {1'b0, w.dvs});
    if (ge) begin
      r = r - {1'b0, w.dvs};
    end
    o.rem = r[DATA_W-1:0];
    o.dq  = {w.dq[DATA_W-2:0], ge};
    return o;
  endfunction

endpackage

`default_nettype wire

>>> rtl/tagged_integer_alu.sv
// Tagged 64-bit integer unit.
// Input channel: in_valid/in_ready carry command, left_tag, left_value,
// right_tag, right_value. Output channel: out_valid/out_ready carry
// result_tag, result_value, error_code. One result per input item, in order.
// The path from input transfer to output valid runs through one capture
// stage, one decode stage (add, subtract, compare, truth, partial products
// of the multiply, operand magnitudes), 64 divider stages that each retire
// one quotient bit, and the output register; the multiply sum is formed in
// the first divider stage. Throughput is one item per cycle while the
// output holds no untaken result.
// The whole pipeline advances together; when the output holds an untaken
// result the pipeline freezes and in_ready drops, so nothing is lost or
// repeated. in_ready stays high while the output register is empty or being
// taken. Reset clears all valid bits; no clearing pass is needed.
`default_nettype none

module tagged_integer_alu (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [3:0]  command,
  input  wire logic [2:0]  left_tag,
  input  wire logic [63:0] left_value,
  input  wire logic [2:0]  right_tag,
  input  wire logic [63:0] right_value,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [1:0]  result_tag,
  output      logic [63:0] result_value,
  output      logic [1:0]  error_code
);

  localparam int unsigned NW = tia_pkg::DIV_STEPS + 1;

  logic                              en;
  tia_pkg::in_t                      cap;
  logic                              cap_v;
  tia_pkg::work_t                    w      [NW];
  logic [NW-1:0]                     wv;
  tia_pkg::work_t                    dec_next;
  tia_pkg::work_t                    step_next [NW];

  // advance everything when the output is free or taken
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // decode the captured item
  always_comb begin
    logic arith, tag_ok, conv, t;
    dec_next = '0;
    arith  = (cap.cmd <= tia_pkg::CMD_GE);
    tag_ok = (cap.ltag == tia_pkg::TAG_INT) && (cap.rtag == tia_pkg::TAG_INT);
    conv   = 1'b1;
    t      = 1'b0;
    dec_next.neg = cap.a[63] ^ cap.b[63];
    dec_next.dq  = cap.a[63] ? (64'd0 - cap.a) : cap.a;
    dec_next.dvs = cap.b[63] ? (64'd0 - cap.b) : cap.b;
    dec_next.pll = {32'd0, cap.a[31:0]} * {32'd0, cap.b[31:0]};
    dec_next.plh = cap.a[31:0] * cap.b[63:32];
    dec_next.phl = cap.a[63:32] * cap.b[31:0];
    dec_next.tag = tia_pkg::RES_ERR;
    dec_next.err = tia_pkg::ERR_TYPE;
    if (arith) begin
      if (tag_ok) begin
        dec_next.err = tia_pkg::ERR_NONE;
        case (cap.cmd)
          tia_pkg::CMD_ADD: begin
            dec_next.tag = tia_pkg::RES_INT;
            dec_next.val = cap.a + cap.b;
          end
          tia_pkg::CMD_SUB: begin
            dec_next.tag = tia_pkg::RES_INT;
            dec_next.val = cap.a - cap.b;
          end
          tia_pkg::CMD_MUL: begin
            dec_next.tag    = tia_pkg::RES_INT;
            dec_next.is_mul = 1'b1;
          end
          tia_pkg::CMD_DIV: begin
            if (cap.b == 64'd0) begin
              dec_next.err = tia_pkg::ERR_DIV0;
            end else begin
              dec_next.tag    = tia_pkg::RES_INT;
              dec_next.is_div = 1'b1;
            end
          end
          tia_pkg::CMD_LT: begin
            dec_next.tag    = tia_pkg::RES_BOOL;
            dec_next.val[0] = $signed(cap.a) < $signed(cap.b);
          end
          tia_pkg::CMD_GT: begin
            dec_next.tag    = tia_pkg::RES_BOOL;
            dec_next.val[0] = $signed(cap.b) < $signed(cap.a);
          end
          tia_pkg::CMD_LE: begin
            dec_next.tag    = tia_pkg::RES_BOOL;
            dec_next.val[0] = !($signed(cap.b) < $signed(cap.a));
          end
          default: begin
            dec_next.tag    = tia_pkg::RES_BOOL;
            dec_next.val[0] = !($signed(cap.a) < $signed(cap.b));
          end
        endcase
      end
    end else if (cap.cmd == tia_pkg::CMD_TRUTH || cap.cmd == tia_pkg::CMD_NOT) begin
      case (cap.ltag)
        tia_pkg::TAG_NONE: t = 1'b0;
        tia_pkg::TAG_BOOL: t = cap.a[0];
        tia_pkg::TAG_OBJ:  t = 1'b1;
        default:           conv = 1'b0;
      endcase
      if (conv) begin
        dec_next.tag    = tia_pkg::RES_BOOL;
        dec_next.err    = tia_pkg::ERR_NONE;
        dec_next.val[0] = t ^ (cap.cmd == tia_pkg::CMD_NOT);
      end else begin
        dec_next.err = tia_pkg::ERR_CONV;
      end
    end
  end

  // divider steps; first one also sums the multiply
  always_comb begin
    step_next[0] = dec_next;
    for (int k = 1; k < NW; k++) begin
      step_next[k] = tia_pkg::div_step(w[k-1]);
      if (k == 1 && w[0].is_mul) begin
        step_next[k].val = w[0].pll + {w[0].plh + w[0].phl, 32'd0};
      end
    end
  end

  // hold valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_v     <= 1'b0;
      wv        <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      cap_v     <= in_valid;
      wv        <= {wv[NW-2:0], cap_v};
      out_valid <= wv[NW-1];
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      cap <= '{cmd: command, ltag: left_tag, a: left_value,
               rtag: right_tag, b: right_value};
      for (int k = 0; k < NW; k++) begin
        w[k] <= step_next[k];
      end
      result_tag   <= w[NW-1].tag;
      error_code   <= w[NW-1].err;
      if (w[NW-1].is_div) begin
        result_value <= w[NW-1].neg ? (64'd0 - w[NW-1].dq) : w[NW-1].dq;
      end else begin
        result_value <= w[NW-1].val;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/tia_checker.sv
`default_nettype none

module tia_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  result_tag,
  input wire logic [63:0] result_value,
  input wire logic [1:0]  error_code
);

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(result_tag))
    else $error("stalled result changed");

  // error tag and error code agree
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((result_tag == tia_pkg::RES_ERR) == (error_code != tia_pkg::ERR_NONE)))
    else $error("error tag and code disagree");

  // errors carry a zero value
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_tag == tia_pkg::RES_ERR |-> result_value == 64'd0)
    else $error("error with nonzero value");

  // booleans use bit 0 only
  a_bool: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_tag == tia_pkg::RES_BOOL |-> result_value[63:1] == 63'd0)
    else $error("boolean with upper bits set");

  // reset drops the output
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind tagged_integer_alu tia_checker u_tia_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready),
  .result_tag(result_tag), .result_value(result_value), .error_code(error_code)
);

`default_nettype wire
